// ----- sv/rtp_header_parser_assert.svh -----
// Assertion macros used by the parser's result queue.
`ifndef RTP_HEADER_PARSER_ASSERT_SVH
`define RTP_HEADER_PARSER_ASSERT_SVH

// Condition holds on every clock edge out of reset.
`define RHP_ASSERT_ALW(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RHP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RHP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rhp_pkg.sv -----
// ----------------------------------------------------------------------------
// rhp_pkg
// Types and constants for the RTP fixed header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

    localparam logic [1:0] KIND_CSRC   = 2'd0;
    localparam logic [1:0] KIND_HDR    = 2'd1;
    localparam logic [1:0] KIND_SHORT  = 2'd2;
    localparam logic [1:0] KIND_TS_INC = 2'd3;

    localparam logic [6:0] HDR_FIXED = 7'd12;
    localparam logic [6:0] MS_BYTES  = 7'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } t_rhp_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  version;
        logic        padding;
        logic        extension;
        logic [3:0]  source_count;
        logic        marker;
        logic [6:0]  pt_code;
        logic [15:0] sequence_res;
        logic [31:0] media_time;
        logic [31:0] sync_source;
        logic [63:0] word;
        logic        last;
    } t_rhp_out;

    // Results produced by one byte: first slot, then optional second slot.
    typedef struct packed {
        logic push0;
        logic push1;
    } t_rhp_push;

endpackage

// ----- sv/rhp_decode.sv -----
// ----------------------------------------------------------------------------
// rhp_decode
// Byte-serial header field capture and result generation.
// ----------------------------------------------------------------------------
module rhp_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rhp_pkg::t_rhp_in  i_in,
    output rhp_pkg::t_rhp_push o_push,
    output rhp_pkg::t_rhp_out o_res0,
    output rhp_pkg::t_rhp_out o_res1
);
    import rhp_pkg::*;

    logic [6:0]  r_byte_pos, n_byte_pos;
    logic        r_done, n_done;
    logic [15:0] r_first, n_first;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_time, n_time;
    logic [31:0] r_ssrc, n_ssrc;
    logic [63:0] r_shift, n_shift;

    logic [3:0]  cc;
    logic [6:0]  hdr_len;
    logic        csrc_hit;
    logic        fin;
    logic        eop;
    logic        err;
    logic        active;
    t_rhp_out    res_csrc, res_hdr, res_err;

    assign eop     = i_in.end_of_packet;
    assign active  = i_accept && !r_done;
    assign cc      = (r_byte_pos == 7'd0) ? i_in.data_byte[3:0] : r_first[11:8];
    assign hdr_len = HDR_FIXED + {1'b0, cc, 2'b00};
    // CSRC words start at offset 12, so the fourth byte has position bits 11
    assign csrc_hit = (r_byte_pos >= HDR_FIXED) && (r_byte_pos < hdr_len)
                      && (r_byte_pos[1:0] == 2'b11);
    assign fin      = r_byte_pos == (hdr_len + MS_BYTES - 7'd1);
    assign err      = eop && !fin;

    always_comb begin
        n_shift    = {r_shift[55:0], i_in.data_byte};
        n_first    = r_first;
        n_seq      = r_seq;
        n_time     = r_time;
        n_ssrc     = r_ssrc;
        n_byte_pos = r_byte_pos;
        n_done     = r_done;
        if (i_accept) begin
            if (r_done) begin
                if (eop) begin
                    n_byte_pos = 7'd0;
                    n_done     = 1'b0;
                end
            end else begin
                if (r_byte_pos == 7'd0) begin
                    n_first = {i_in.data_byte, 8'h00};
                end else if (r_byte_pos == 7'd1) begin
                    n_first = {r_first[15:8], i_in.data_byte};
                end else if (r_byte_pos < 7'd4) begin
                    n_seq = n_shift[15:0];
                end else if (r_byte_pos < 7'd8) begin
                    n_time = n_shift[31:0];
                end else if (r_byte_pos < HDR_FIXED) begin
                    n_ssrc = n_shift[31:0];
                end
                if (eop) begin
                    n_byte_pos = 7'd0;
                end else begin
                    n_byte_pos = r_byte_pos + 7'd1;
                    n_done     = fin;
                end
            end
        end
    end

    always_comb begin
        // Filled results only occur at position 12 or later, when all
        // header registers hold their final values.
        res_csrc              = '0;
        res_csrc.kind         = KIND_CSRC;
        res_csrc.version      = r_first[15:14];
        res_csrc.padding      = r_first[13];
        res_csrc.extension    = r_first[12];
        res_csrc.source_count = r_first[11:8];
        res_csrc.marker       = r_first[7];
        res_csrc.pt_code      = r_first[6:0];
        res_csrc.sequence_res = r_seq;
        res_csrc.media_time   = r_time;
        res_csrc.sync_source  = r_ssrc;
        res_csrc.word         = {32'd0, n_shift[31:0]};

        res_hdr      = res_csrc;
        res_hdr.kind = KIND_HDR;
        res_hdr.word = n_shift;

        res_err      = '0;
        res_err.kind = ((r_byte_pos + 7'd1) < hdr_len) ? KIND_SHORT : KIND_TS_INC;
        res_err.last = 1'b1;
    end

    always_comb begin
        o_push.push0 = active && (csrc_hit || fin || err);
        o_push.push1 = active && csrc_hit && err;
        if (csrc_hit) begin
            o_res0 = res_csrc;
        end else if (fin) begin
            o_res0 = res_hdr;
        end else begin
            o_res0 = res_err;
        end
        o_res0.last = !(csrc_hit && err);
        o_res1      = res_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= '0;
            r_done     <= 1'b0;
            r_first    <= '0;
            r_seq      <= '0;
            r_time     <= '0;
            r_ssrc     <= '0;
            r_shift    <= '0;
        end else begin
            r_byte_pos <= n_byte_pos;
            r_done     <= n_done;
            r_first    <= n_first;
            r_seq      <= n_seq;
            r_time     <= n_time;
            r_ssrc     <= n_ssrc;
            if (active) begin
                r_shift <= n_shift;
            end
        end
    end

endmodule

// ----- sv/rhp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// rhp_out_fifo
// Four-entry result queue taking up to two results per cycle.
// ----------------------------------------------------------------------------
`include "rtp_header_parser_assert.svh"

module rhp_out_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rhp_pkg::t_rhp_push i_push,
    input  rhp_pkg::t_rhp_out  i_res0,
    input  rhp_pkg::t_rhp_out  i_res1,
    output logic               o_nearly_full,
    output logic               o_valid,
    input  logic               i_stall,
    output rhp_pkg::t_rhp_out  o_data
);
    import rhp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_rhp_out        r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            pop;

    assign o_valid       = r_count != '0;
    assign o_data        = r_mem[r_rd];
    assign pop           = o_valid && !i_stall;
    // Keep two slots free so any accepted byte fits
    assign o_nearly_full = r_count > CW'(DEPTH - 2);

    always_comb begin
        n_wr    = r_wr + PW'(i_push.push0) + PW'(i_push.push1);
        n_rd    = r_rd + PW'(pop);
        n_count = r_count + CW'(i_push.push0) + CW'(i_push.push1) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr + PW'(1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `RHP_ASSERT_ALW(a_count_max, i_clk, i_rst_n, r_count <= CW'(DEPTH), "fifo overflow")
    `RHP_ASSERT_IMP(a_push_order, i_clk, i_rst_n, i_push.push1, i_push.push0, "second push alone")
    `RHP_ASSERT_IMP(a_room, i_clk, i_rst_n, i_push.push0, !o_nearly_full, "push without room")
    `RHP_ASSERT_NXT(a_drain, i_clk, i_rst_n, pop && !i_push.push0,
                    r_count == $past(r_count) - CW'(1), "count not reduced on pop")

endmodule

// ----- sv/rtp_header_parser.sv -----
// A result is queued when its byte is accepted, behind any earlier results.
// Throughput: one byte per cycle; a byte causing two results (CSRC word plus
// an end-of-packet error) fills two slots of the four-entry result queue,
// which drains one result per cycle, so input stalls only under backpressure.
// Reset: synchronous active low; parser returns to byte 0, queue empties.
// ----------------------------------------------------------------------------
// rtp_header_parser
// Byte-serial RTP fixed header decoder with CSRC and timestamp results.
// ----------------------------------------------------------------------------
module rtp_header_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rhp_pkg::t_rhp_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rhp_pkg::t_rhp_out o_out_data
);
    import rhp_pkg::*;

    t_rhp_push push;
    t_rhp_out  res0, res1;
    logic      accept;
    logic      nearly_full;

    assign o_in_stall = nearly_full;
    assign accept     = i_in_valid && !nearly_full;

    rhp_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in_data),
        .o_push   (push),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    rhp_out_fifo u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_res0        (res0),
        .i_res1        (res1),
        .o_nearly_full (nearly_full),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_data        (o_out_data)
    );

endmodule
